// ----- src/wdi_pkg.sv -----
// Shared types and constants for the word dictionary indexer.
// No dependencies.
`default_nettype none
package wdi_pkg;
	localparam int unsigned DictDepthDef  = 1024;
	localparam int unsigned MaxWordLenDef = 140;

	localparam logic [7:0] ChSpace = 8'd32;
	localparam logic [7:0] ChTab   = 8'd9;
	localparam logic [7:0] ChNl    = 8'd10;
	localparam logic [7:0] ChNul   = 8'd0;
	localparam logic [7:0] ChAt    = 8'h40;
	localparam logic [7:0] ChT     = 8'h74;
	localparam logic [7:0] ChH     = 8'h68;
	localparam logic [7:0] ChE     = 8'h65;

	localparam logic [1:0] CfgMinLen   = 2'd0;
	localparam logic [1:0] CfgMaxWords = 2'd1;

	localparam logic [31:0] CountMax = 32'hFFFF_FFFF;

	typedef struct packed {
		logic [7:0] char_code;
		logic       end_of_message;
	} item_t;

	typedef struct packed {
		logic [9:0]  word_index;
		logic        is_end_marker;
		logic        is_new_word;
		logic [31:0] word_total;
		logic        dictionary_full;
		logic        last;
	} result_t;

	// one job per accepted item that yields any result
	typedef struct packed {
		logic       has_word;
		logic       is_end;
		logic [7:0] len;
	} job_t;
endpackage
`default_nettype wire

// ----- src/wdi_front.sv -----
// Front end: config registers, word splitting, filtering and the word buffer.
// Depends on wdi_pkg.
`default_nettype none
module wdi_front #(
	parameter int unsigned MAX_WORD_LEN = 140
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire wdi_pkg::item_t item,
	output logic               busy,
	input  wire logic          cfg_we,
	input  wire logic [1:0]    cfg_index,
	input  wire logic [7:0]    cfg_data,
	input  wire logic          q_full,
	output logic               push,
	output wdi_pkg::job_t      push_job,
	input  wire logic          word_done,
	input  wire logic [$clog2(MAX_WORD_LEN)-1:0] wbuf_addr,
	output logic [7:0]         wbuf_data
);
	import wdi_pkg::*;
	localparam int unsigned MW = $clog2(MAX_WORD_LEN);

	logic [7:0] min_len_q;
	logic [5:0] max_words_q;
	logic [7:0] len_q;
	logic [5:0] kept_q;
	logic [7:0] c0_q, c1_q, c2_q;
	logic       pending_q;
	logic [7:0] wbuf [MAX_WORD_LEN];

	logic       acc, sep, app, fin, keepw, is_the;
	logic [7:0] nlen, nc0, nc1, nc2;

	assign busy = pending_q || q_full;
	assign acc  = start && !busy;

	always_comb begin
		sep = (item.char_code == ChSpace) || (item.char_code == ChTab) ||
		      (item.char_code == ChNl) || (item.char_code == ChNul);
		app  = !sep && (len_q < 8'(MAX_WORD_LEN));
		nlen = len_q + {7'd0, app};
		nc0  = (app && len_q == 8'd0) ? item.char_code : c0_q;
		nc1  = (app && len_q == 8'd1) ? item.char_code : c1_q;
		nc2  = (app && len_q == 8'd2) ? item.char_code : c2_q;
		fin  = sep || item.end_of_message;
		is_the = (nlen == 8'd3) && nc0 == ChT && nc1 == ChH && nc2 == ChE;
		keepw = fin && nlen != 8'd0 && kept_q < max_words_q && nlen >= min_len_q &&
		        nc0 != ChAt && !is_the;
		push = acc && (keepw || item.end_of_message);
		push_job.has_word = keepw;
		push_job.is_end   = item.end_of_message;
		push_job.len      = nlen;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_len_q   <= 8'd3;
			max_words_q <= 6'd36;
			len_q       <= '0;
			kept_q      <= '0;
			pending_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CfgMinLen:   min_len_q   <= cfg_data;
					CfgMaxWords: max_words_q <= cfg_data[5:0];
					default: ;
				endcase
			end
			if (acc) begin
				len_q <= fin ? 8'd0 : nlen;
				if (item.end_of_message)
					kept_q <= '0;
				else if (keepw)
					kept_q <= kept_q + 6'd1;
			end
			if (push && keepw)
				pending_q <= 1'b1;
			else if (word_done)
				pending_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			c0_q <= nc0;
			c1_q <= nc1;
			c2_q <= nc2;
		end
	end

	always_ff @(posedge clk) begin
		if (acc && app)
			wbuf[len_q[MW-1:0]] <= item.char_code;
		wbuf_data <= wbuf[wbuf_addr];
	end
endmodule
`default_nettype wire

// ----- src/wdi_queue.sv -----
// Two-entry job queue between front and back.
// Depends on wdi_pkg.
`default_nettype none
module wdi_queue (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     push,
	input  wire wdi_pkg::job_t push_job,
	input  wire logic     pop,
	output logic          q_valid,
	output logic          q_full,
	output wdi_pkg::job_t q_job
);
	import wdi_pkg::*;

	job_t       ent_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;

	assign q_valid = cnt_q != 2'd0;
	assign q_full  = cnt_q == 2'd2;
	assign q_job   = ent_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push)
				wp_q <= !wp_q;
			if (pop)
				rp_q <= !rp_q;
			if (push && !pop)
				cnt_q <= cnt_q + 2'd1;
			else if (pop && !push)
				cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			ent_q[wp_q] <= push_job;
	end
endmodule
`default_nettype wire

// ----- src/wdi_back.sv -----
// Back end: dictionary memories, linear search, count update, append, results.
// Depends on wdi_pkg.
`default_nettype none
module wdi_back #(
	parameter int unsigned DICT_DEPTH   = 1024,
	parameter int unsigned MAX_WORD_LEN = 140
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       q_valid,
	input  wire wdi_pkg::job_t q_job,
	output logic            pop,
	output logic            word_done,
	output logic [$clog2(MAX_WORD_LEN)-1:0] wbuf_addr,
	input  wire logic [7:0] wbuf_data,
	output logic            result_valid,
	output wdi_pkg::result_t result
);
	import wdi_pkg::*;
	localparam int unsigned MW  = $clog2(MAX_WORD_LEN);
	localparam int unsigned AW  = $clog2(DICT_DEPTH);
	localparam int unsigned IW  = $clog2(DICT_DEPTH + 1);
	localparam int unsigned CAW = $clog2(DICT_DEPTH * MAX_WORD_LEN);
	localparam int unsigned BW  = $clog2(DICT_DEPTH * MAX_WORD_LEN + 1);

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_LEN  = 4'd1;
	localparam logic [3:0] S_LENC = 4'd2;
	localparam logic [3:0] S_CHR  = 4'd3;
	localparam logic [3:0] S_CHC  = 4'd4;
	localparam logic [3:0] S_HIT  = 4'd5;
	localparam logic [3:0] S_MISS = 4'd6;
	localparam logic [3:0] S_CPY  = 4'd7;
	localparam logic [3:0] S_CPW  = 4'd8;
	localparam logic [3:0] S_END  = 4'd9;

	logic [7:0]  chars [DICT_DEPTH * MAX_WORD_LEN];
	logic [7:0]  lens  [DICT_DEPTH];
	logic [31:0] cnts  [DICT_DEPTH];

	logic [3:0]    st_q;
	job_t          job_q;
	logic [IW-1:0] idx_q, size_q;
	logic [BW-1:0] base_q;
	logic [MW-1:0] j_q;
	logic [7:0]    len_rd_q, chr_rd_q;
	logic [31:0]   cnt_rd_q;

	logic [CAW-1:0] caddr;
	logic           lastb, ch_we, ent_we;
	logic [31:0]    cnt_wd, cnt_inc;
	logic [IW-1:0]  idx_nx;

	assign wbuf_addr = j_q;
	assign caddr   = CAW'(base_q + BW'(j_q));
	assign lastb   = (8'(j_q) == job_q.len - 8'd1);
	assign cnt_inc = (cnt_rd_q == CountMax) ? cnt_rd_q : cnt_rd_q + 32'd1;
	assign idx_nx  = idx_q + IW'(1);
	assign ch_we   = st_q == S_CPW;
	assign ent_we  = (st_q == S_CPW && lastb) || st_q == S_HIT;
	assign cnt_wd  = (st_q == S_HIT) ? cnt_inc : 32'd1;
	assign pop     = st_q == S_IDLE && q_valid;

	always_ff @(posedge clk) begin
		if (ch_we)
			chars[caddr] <= wbuf_data;
		chr_rd_q <= chars[caddr];
	end

	always_ff @(posedge clk) begin
		if (ent_we && st_q == S_CPW)
			lens[idx_q[AW-1:0]] <= job_q.len;
		len_rd_q <= lens[idx_q[AW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (ent_we)
			cnts[idx_q[AW-1:0]] <= cnt_wd;
		cnt_rd_q <= cnts[idx_q[AW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q         <= S_IDLE;
			size_q       <= '0;
			result_valid <= 1'b0;
			word_done    <= 1'b0;
		end else begin
			result_valid <= 1'b0;
			word_done    <= 1'b0;
			case (st_q)
				S_IDLE: begin
					if (q_valid) begin
						if (q_job.has_word)
							st_q <= (size_q == '0) ? S_MISS : S_LEN;
						else
							st_q <= S_END;
					end
				end
				S_LEN: st_q <= S_LENC;
				S_LENC: begin
					if (len_rd_q == job_q.len)
						st_q <= S_CHR;
					else
						st_q <= (idx_nx == size_q) ? S_MISS : S_LEN;
				end
				S_CHR: st_q <= S_CHC;
				S_CHC: begin
					if (chr_rd_q != wbuf_data)
						st_q <= (idx_nx == size_q) ? S_MISS : S_LEN;
					else
						st_q <= lastb ? S_HIT : S_CHR;
				end
				S_HIT: begin
					result_valid <= 1'b1;
					word_done    <= 1'b1;
					st_q         <= job_q.is_end ? S_END : S_IDLE;
				end
				S_MISS: begin
					if (size_q == IW'(DICT_DEPTH)) begin
						result_valid <= 1'b1;
						word_done    <= 1'b1;
						st_q         <= job_q.is_end ? S_END : S_IDLE;
					end else begin
						st_q <= S_CPY;
					end
				end
				S_CPY: st_q <= S_CPW;
				S_CPW: begin
					if (lastb) begin
						size_q       <= size_q + IW'(1);
						result_valid <= 1'b1;
						word_done    <= 1'b1;
						st_q         <= job_q.is_end ? S_END : S_IDLE;
					end else begin
						st_q <= S_CPY;
					end
				end
				S_END: begin
					result_valid <= 1'b1;
					st_q         <= S_IDLE;
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (st_q)
			S_IDLE: begin
				job_q  <= q_job;
				idx_q  <= '0;
				base_q <= '0;
				j_q    <= '0;
			end
			S_LENC: begin
				j_q <= '0;
				if (len_rd_q != job_q.len) begin
					idx_q  <= idx_nx;
					base_q <= base_q + BW'(MAX_WORD_LEN);
				end
			end
			S_CHC: begin
				if (chr_rd_q != wbuf_data) begin
					idx_q  <= idx_nx;
					base_q <= base_q + BW'(MAX_WORD_LEN);
				end else if (!lastb) begin
					j_q <= j_q + MW'(1);
				end
			end
			S_MISS: j_q <= '0;
			S_CPW: if (!lastb) j_q <= j_q + MW'(1);
			default: ;
		endcase
		case (st_q)
			S_HIT: result <= '{word_index: 10'(idx_q), is_end_marker: 1'b0,
				is_new_word: 1'b0, word_total: cnt_inc, dictionary_full: 1'b0,
				last: !job_q.is_end};
			S_MISS: result <= '{word_index: 10'd0, is_end_marker: 1'b0,
				is_new_word: 1'b0, word_total: 32'd0, dictionary_full: 1'b1,
				last: !job_q.is_end};
			S_CPW: result <= '{word_index: 10'(idx_q), is_end_marker: 1'b0,
				is_new_word: 1'b1, word_total: 32'd1, dictionary_full: 1'b0,
				last: !job_q.is_end};
			S_END: result <= '{word_index: 10'd0, is_end_marker: 1'b1,
				is_new_word: 1'b0, word_total: 32'd0, dictionary_full: 1'b0,
				last: 1'b1};
			default: ;
		endcase
	end
endmodule
`default_nettype wire

// ----- src/word_dictionary_indexer_unit.sv -----
// Top level of the word dictionary indexer: front, job queue, back.
// Depends on wdi_pkg, wdi_front, wdi_queue, wdi_back.
//
// Bytes are taken one per cycle while busy is low; a byte that ends a kept
// word raises busy until that word's dictionary lookup is done, since the word
// buffer is shared, and busy is also high while the two-entry job queue is
// full. The lookup walks the dictionary entries in order, reading each entry's
// length and comparing bytes only on entries of equal length; a new word is
// copied in byte by byte. Results appear on result for one cycle, marked by
// result_valid, and cannot be held off. No clearing pass follows reset.
`default_nettype none
module word_dictionary_indexer_unit #(
	parameter int unsigned DICT_DEPTH   = wdi_pkg::DictDepthDef,
	parameter int unsigned MAX_WORD_LEN = wdi_pkg::MaxWordLenDef
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire wdi_pkg::item_t item,
	output logic             busy,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [7:0]  cfg_data,
	output logic             result_valid,
	output wdi_pkg::result_t result
);
	import wdi_pkg::*;
	localparam int unsigned MW = $clog2(MAX_WORD_LEN);

	logic          q_full, q_valid, push, pop, word_done;
	job_t          push_job, q_job;
	logic [MW-1:0] wbuf_addr;
	logic [7:0]    wbuf_data;

	wdi_front #(.MAX_WORD_LEN(MAX_WORD_LEN)) u_front (
		.clk, .arst_n, .start, .item, .busy, .cfg_we, .cfg_index, .cfg_data,
		.q_full, .push, .push_job, .word_done, .wbuf_addr, .wbuf_data
	);

	wdi_queue u_queue (
		.clk, .arst_n, .push, .push_job, .pop, .q_valid, .q_full, .q_job
	);

	wdi_back #(.DICT_DEPTH(DICT_DEPTH), .MAX_WORD_LEN(MAX_WORD_LEN)) u_back (
		.clk, .arst_n, .q_valid, .q_job, .pop, .word_done, .wbuf_addr,
		.wbuf_data, .result_valid, .result
	);

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && q_full && !pop)) else $error("job queue overflow");

	a_end_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.is_end_marker |-> result.last &&
		!result.is_new_word && result.word_total == 32'd0)
		else $error("bad end marker");

	a_full_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.dictionary_full |-> result.word_index == 10'd0 &&
		result.word_total == 32'd0 && !result.is_new_word)
		else $error("bad full result");

	a_done_valid: assert property (@(posedge clk) disable iff (!arst_n)
		word_done |-> result_valid && !result.is_end_marker)
		else $error("word finished without result");
endmodule
`default_nettype wire
